// ----- design/scatr_pkg.sv -----
// Shared types, codes and lookup tables for the ATR parser with PPS request.
// No dependencies; used by the top level.
package scatr_pkg;

  // One-hot parse phase
  typedef enum logic [12:0] {
    PH_IDLE = 13'b0_0000_0000_0001,
    PH_TS   = 13'b0_0000_0000_0010,
    PH_T0   = 13'b0_0000_0000_0100,
    PH_TA1  = 13'b0_0000_0000_1000,
    PH_TB1  = 13'b0_0000_0001_0000,
    PH_TC1  = 13'b0_0000_0010_0000,
    PH_TD1  = 13'b0_0000_0100_0000,
    PH_TA2  = 13'b0_0000_1000_0000,
    PH_TB2  = 13'b0_0001_0000_0000,
    PH_TC2  = 13'b0_0010_0000_0000,
    PH_TD2  = 13'b0_0100_0000_0000,
    PH_HIST = 13'b0_1000_0000_0000,
    PH_ECHO = 13'b1_0000_0000_0000
  } phase_t;

  // Bit position of TA1 inside the one-hot phase vector
  localparam int PH_TA1_POS = 3;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_PPS  = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
  localparam logic [2:0] ERR_INVERSE  = 3'd2;
  localparam logic [2:0] ERR_NOT_T0   = 3'd3;
  localparam logic [2:0] ERR_TA2      = 3'd4;
  localparam logic [2:0] ERR_MISMATCH = 3'd5;

  localparam logic [7:0] TS_DIRECT = 8'h3B;
  localparam logic [7:0] PPSS      = 8'hFF;
  localparam logic [7:0] PPS0_BASE = 8'h10;

  // Most results one accepted beat can cause
  localparam int MAX_RES = 4;

  // Result queue depth; pointers wrap by overflow, so keep it a power of two
  localparam int OUT_DEPTH = 8;

  // Compact queued result; Fi and Di are rebuilt from ta1 on the way out
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [2:0] err;
    logic [7:0] ta1;
    logic [3:0] hist;
  } res_t;

  function automatic logic [11:0] fi_lookup(input logic [2:0] idx);
    logic [11:0] v;
    case (idx)
      3'd1:    v = 12'd512;
      3'd2:    v = 12'd768;
      3'd3:    v = 12'd1024;
      3'd4:    v = 12'd1536;
      3'd5:    v = 12'd2048;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] di_lookup(input logic [2:0] idx);
    logic [6:0] v;
    case (idx)
      3'd1:    v = 7'd1;
      3'd2:    v = 7'd2;
      3'd3:    v = 7'd4;
      3'd4:    v = 7'd8;
      3'd5:    v = 7'd16;
      3'd6:    v = 7'd32;
      3'd7:    v = 7'd64;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/scatr_if.sv -----
// Valid/ready channel interfaces for the ATR parser: event input and result output.
// Depends on nothing but the port widths fixed here.
interface scatr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface scatr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  error_code;
  logic [11:0] clock_rate_factor;
  logic [6:0]  baud_adjust_factor;
  logic [7:0]  interface_ta1;
  logic [3:0]  historical_count;

  modport source (output valid, output kind, output tx_byte, output last,
                  output error_code, output clock_rate_factor,
                  output baud_adjust_factor, output interface_ta1,
                  output historical_count, input ready);
  modport sink   (input valid, input kind, input tx_byte, input last,
                  input error_code, input clock_rate_factor,
                  input baud_adjust_factor, input interface_ta1,
                  input historical_count, output ready);
endinterface

// ----- design/smartcard_atr_parse_pps.sv -----
// ISO 7816-3 answer-to-reset parser with PPS request and echo check.
// Depends on scatr_pkg and the channel interfaces in scatr_if.sv.
//
// One event beat (start, received byte, timeout) is taken per clock. Each beat is
// parsed in the cycle it is accepted and its results land in an OUT_DEPTH-entry
// result queue, visible on the output in the next cycle and drained one per clock
// while the output is ready. The end of the ATR pushes four PPS bytes at once, so
// the input is ready only while the queue has at least four free slots. With an
// output that is always ready a single activation never stalls the input, but
// activations that end every few beats (start, TS, T0 closing the ATR) make
// results faster than one per clock, and then the input waits for the queue to
// drain; otherwise the rate is one event per cycle.
// A start command restarts parsing at any time; the queue keeps any results
// already produced.
module smartcard_atr_parse_pps (
  input  logic               clk,
  input  logic               rst_n,
  scatr_in_if.sink           in_ch,
  scatr_out_if.source        out_ch
);

  localparam int QAW = $clog2(scatr_pkg::OUT_DEPTH);
  localparam int QCW = $clog2(scatr_pkg::OUT_DEPTH + 1);
  localparam logic [QCW-1:0] READY_MAX = QCW'(scatr_pkg::OUT_DEPTH - scatr_pkg::MAX_RES);
  // TA1..TD2 occupy phase bits 3..10; the window starts one below at T0
  localparam int WIN_LO = scatr_pkg::PH_TA1_POS - 1;
  localparam int WIN_HI = scatr_pkg::PH_TA1_POS + 6;

  scatr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] fmt_r, fmt_nxt;
  logic [7:0] conv_r, conv_nxt;
  logic [7:0] td1_r, td1_nxt;
  logic [7:0] ta1_r, ta1_nxt;
  logic [3:0] hist_r, hist_nxt;
  logic [1:0] echo_r, echo_nxt;
  logic [7:0] pps_sent_r [4];
  logic [7:0] pps_nxt [4];
  logic       pps_we;

  scatr_pkg::res_t q_r [scatr_pkg::OUT_DEPTH];
  scatr_pkg::res_t push_ent [scatr_pkg::MAX_RES];
  logic [2:0]      n_push;
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]  cnt_r, cnt_nxt;

  logic       in_acc, pop, busy;
  logic       do_adv, do_finish, do_fail;
  logic [2:0] fail_code;
  logic [7:0] pres, above, cand;
  logic [7:0] cur;
  logic       acc_or, found;
  logic [2:0] sel;
  scatr_pkg::res_t head;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign busy   = (phase_r != scatr_pkg::PH_IDLE);
  assign in_ch.ready = (cnt_r <= READY_MAX);

  always_comb begin
    phase_nxt = phase_r;
    fmt_nxt   = fmt_r;
    conv_nxt  = conv_r;
    td1_nxt   = td1_r;
    ta1_nxt   = ta1_r;
    hist_nxt  = hist_r;
    echo_nxt  = echo_r;
    for (int k = 0; k < 4; k++) begin
      pps_nxt[k] = pps_sent_r[k];
    end
    pps_we    = 1'b0;
    n_push    = 3'd0;
    for (int k = 0; k < scatr_pkg::MAX_RES; k++) begin
      push_ent[k] = '0;
    end
    do_adv    = 1'b0;
    do_finish = 1'b0;
    do_fail   = 1'b0;
    fail_code = scatr_pkg::ERR_NONE;
    pres      = '0;
    above     = '0;
    cand      = '0;
    cur       = '0;
    acc_or    = 1'b0;
    found     = 1'b0;
    sel       = '0;

    if (in_acc) begin
      case (in_ch.cmd)
        scatr_pkg::CMD_START: begin
          phase_nxt = scatr_pkg::PH_TS;
          fmt_nxt   = '0;
          conv_nxt  = '0;
          td1_nxt   = '0;
          ta1_nxt   = '0;
          hist_nxt  = '0;
          echo_nxt  = '0;
        end
        scatr_pkg::CMD_TIMEOUT: begin
          if (busy) begin
            do_fail   = 1'b1;
            fail_code = scatr_pkg::ERR_TIMEOUT;
          end
        end
        scatr_pkg::CMD_BYTE: begin
          unique case (phase_r)
            scatr_pkg::PH_TS: begin
              conv_nxt  = in_ch.rx_byte;
              phase_nxt = scatr_pkg::PH_T0;
            end
            scatr_pkg::PH_T0: begin
              fmt_nxt  = in_ch.rx_byte;
              hist_nxt = in_ch.rx_byte[3:0];
              do_adv   = 1'b1;
            end
            scatr_pkg::PH_TA1: begin
              ta1_nxt = in_ch.rx_byte;
              do_adv  = 1'b1;
            end
            scatr_pkg::PH_TD1: begin
              td1_nxt = in_ch.rx_byte;
              do_adv  = 1'b1;
            end
            scatr_pkg::PH_TB1, scatr_pkg::PH_TC1, scatr_pkg::PH_TA2,
            scatr_pkg::PH_TB2, scatr_pkg::PH_TC2, scatr_pkg::PH_TD2: begin
              do_adv = 1'b1;
            end
            scatr_pkg::PH_HIST: begin
              hist_nxt = hist_r - 4'd1;
              if (hist_r == 4'd1) begin
                do_finish = 1'b1;
              end
            end
            scatr_pkg::PH_ECHO: begin
              if (in_ch.rx_byte != pps_sent_r[echo_r]) begin
                do_fail   = 1'b1;
                fail_code = scatr_pkg::ERR_MISMATCH;
              end else if (echo_r == 2'd3) begin
                phase_nxt        = scatr_pkg::PH_IDLE;
                echo_nxt         = '0;
                n_push           = 3'd1;
                push_ent[0].kind = scatr_pkg::KIND_OK;
                push_ent[0].last = 1'b1;
                push_ent[0].ta1  = ta1_r;
                push_ent[0].hist = fmt_r[3:0];
              end else begin
                echo_nxt = echo_r + 2'd1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // Next interface byte: lowest presence bit past the current position
    if (do_adv) begin
      pres = {td1_nxt[7:4], fmt_nxt[7:4]};
      cur  = phase_r[WIN_HI:WIN_LO];
      for (int i = 0; i < 8; i++) begin
        acc_or   = acc_or | cur[i];
        above[i] = acc_or;
      end
      cand = pres & above;
      for (int i = 7; i >= 0; i--) begin
        if (cand[i]) begin
          found = 1'b1;
          sel   = 3'(i);
        end
      end
      if (found) begin
        phase_nxt = scatr_pkg::phase_t'(13'b1 << (sel + 4'(scatr_pkg::PH_TA1_POS)));
      end else if (hist_nxt != 4'd0) begin
        phase_nxt = scatr_pkg::PH_HIST;
      end else begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      if (conv_nxt != scatr_pkg::TS_DIRECT) begin
        do_fail   = 1'b1;
        fail_code = scatr_pkg::ERR_INVERSE;
      end else if (td1_nxt[3:0] != 4'd0) begin
        do_fail   = 1'b1;
        fail_code = scatr_pkg::ERR_NOT_T0;
      end else if (td1_nxt[4]) begin
        do_fail   = 1'b1;
        fail_code = scatr_pkg::ERR_TA2;
      end else begin
        pps_we     = 1'b1;
        pps_nxt[0] = scatr_pkg::PPSS;
        pps_nxt[1] = scatr_pkg::PPS0_BASE | {4'd0, td1_nxt[3:0]};
        pps_nxt[2] = ta1_nxt;
        pps_nxt[3] = scatr_pkg::PPSS ^ (scatr_pkg::PPS0_BASE | {4'd0, td1_nxt[3:0]})
                     ^ ta1_nxt;
        n_push     = 3'd4;
        for (int k = 0; k < scatr_pkg::MAX_RES; k++) begin
          push_ent[k].kind    = scatr_pkg::KIND_PPS;
          push_ent[k].tx_byte = pps_nxt[k];
          push_ent[k].last    = (k == scatr_pkg::MAX_RES - 1);
        end
        echo_nxt  = '0;
        phase_nxt = scatr_pkg::PH_ECHO;
      end
    end

    if (do_fail) begin
      phase_nxt        = scatr_pkg::PH_IDLE;
      n_push           = 3'd1;
      push_ent[0]      = '0;
      push_ent[0].kind = scatr_pkg::KIND_FAIL;
      push_ent[0].last = 1'b1;
      push_ent[0].err  = fail_code;
    end
  end

  assign cnt_nxt = cnt_r + QCW'(n_push) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= scatr_pkg::PH_IDLE;
      fmt_r    <= '0;
      conv_r   <= '0;
      td1_r    <= '0;
      ta1_r    <= '0;
      hist_r   <= '0;
      echo_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      fmt_r    <= fmt_nxt;
      conv_r   <= conv_nxt;
      td1_r    <= td1_nxt;
      ta1_r    <= ta1_nxt;
      hist_r   <= hist_nxt;
      echo_r   <= echo_nxt;
      wr_ptr_r <= wr_ptr_r + QAW'(n_push);
      rd_ptr_r <= rd_ptr_r + QAW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pps_we) begin
      for (int k = 0; k < 4; k++) begin
        pps_sent_r[k] <= pps_nxt[k];
      end
    end
    for (int k = 0; k < scatr_pkg::MAX_RES; k++) begin
      if (3'(k) < n_push) begin
        q_r[wr_ptr_r + QAW'(k)] <= push_ent[k];
      end
    end
  end

  assign head = q_r[rd_ptr_r];

  assign out_ch.valid              = (cnt_r != '0);
  assign out_ch.kind               = head.kind;
  assign out_ch.tx_byte            = head.tx_byte;
  assign out_ch.last               = head.last;
  assign out_ch.error_code         = head.err;
  assign out_ch.clock_rate_factor  = scatr_pkg::fi_lookup(head.ta1[6:4]);
  assign out_ch.baud_adjust_factor = scatr_pkg::di_lookup(head.ta1[2:0]);
  assign out_ch.interface_ta1      = head.ta1;
  assign out_ch.historical_count   = head.hist;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(scatr_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == scatr_pkg::CMD_TIMEOUT && busy)
      |=> phase_r == scatr_pkg::PH_IDLE && cnt_r != '0)
    else $error("timeout did not end the activation with a result");

  a_echo_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r == scatr_pkg::PH_ECHO)
      |-> echo_r == 2'd0 && pps_sent_r[0] == scatr_pkg::PPSS
          && cnt_r >= QCW'(scatr_pkg::MAX_RES))
    else $error("echo phase entered without a full PPS request");

endmodule
